// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// property checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/lz78be_pkg.sv =====
// shared types and constants for the lz78 byte encoder
// no dependencies
`timescale 1ns / 1ps

package lz78be_pkg;

    localparam int DICT_SIZE_DEF = 256;
    localparam int BYTE_W        = 8;

    // commands from the controller to the datapath
    typedef struct packed {
        logic start;       // request accepted, latch byte and set up the scan
        logic scan_en;     // advance the dictionary scan by one entry
        logic hit_step;    // hit without end of stream, move the match
        logic hit_flush;   // hit on the last byte, emit the index alone
        logic miss;        // no entry found, add one and emit the pair
    } lz78be_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic hit;         // registered entry matches (match, byte)
        logic exhausted;   // every entry compared, none matched
        logic last;        // current byte ends the stream
        logic out_free;    // result register can take a new result
    } lz78be_stat_t;

endpackage

// ===== hw/rtl/lz78be_dp.sv =====
// datapath of the lz78 byte encoder: dictionary memory, scan, match and result register
// depends on lz78be_pkg
`timescale 1ns / 1ps

module lz78be_dp
    import lz78be_pkg::*;
#(
    parameter int DICT_SIZE = DICT_SIZE_DEF,
    localparam int IDX_W    = $clog2(DICT_SIZE),
    localparam int ENT_W    = IDX_W + BYTE_W
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  lz78be_cmd_t        cmd,
    output lz78be_stat_t       stat,
    input  logic [BYTE_W-1:0]  in_byte,
    input  logic               in_last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [IDX_W-1:0]   out_prefix,
    output logic [BYTE_W-1:0]  out_symbol,
    output logic               out_has_symbol
);

    logic [ENT_W-1:0]  mem [DICT_SIZE];

    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic [IDX_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  match_reg, match_next;
    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic              issuing_reg, issuing_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [ENT_W-1:0]  rd_data_reg;
    logic              m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]  prefix_reg;
    logic [BYTE_W-1:0] symbol_reg;
    logic              has_symbol_reg;

    logic              full;
    logic              rd_en;
    logic              take;
    logic [IDX_W-1:0]  wr_addr;

    assign full    = (count_reg == IDX_W'(DICT_SIZE - 1));
    assign rd_en   = cmd.scan_en && issuing_reg;
    assign take    = cmd.hit_flush || cmd.miss;
    assign wr_addr = count_reg + IDX_W'(1);

    assign stat.hit       = rd_valid_reg && (rd_data_reg == {match_reg, byte_reg});
    assign stat.exhausted = !issuing_reg && !rd_valid_reg;
    assign stat.last      = last_reg;
    assign stat.out_free  = !m_valid_reg || out_ready;

    always_comb begin
        count_next    = count_reg;
        match_next    = match_reg;
        addr_next     = addr_reg;
        issuing_next  = issuing_reg;
        rd_valid_next = rd_valid_reg;
        if (cmd.start) begin
            // a full dictionary starts over; the match is always the root here
            if (full) begin
                count_next = '0;
                match_next = '0;
            end
            addr_next     = IDX_W'(1);
            issuing_next  = !full && (count_reg != '0);
            rd_valid_next = 1'b0;
        end else if (cmd.scan_en) begin
            if (issuing_reg) begin
                addr_next     = addr_reg + IDX_W'(1);
                issuing_next  = (addr_reg != count_reg);
                rd_valid_next = 1'b1;
            end else begin
                rd_valid_next = 1'b0;
            end
        end else if (cmd.hit_step) begin
            match_next    = rd_idx_reg;
            issuing_next  = 1'b0;
            rd_valid_next = 1'b0;
        end else if (cmd.hit_flush) begin
            count_next    = '0;
            match_next    = '0;
            issuing_next  = 1'b0;
            rd_valid_next = 1'b0;
        end else if (cmd.miss) begin
            count_next = last_reg ? '0 : wr_addr;
            match_next = '0;
        end
    end

    always_comb begin
        if (take) begin
            m_valid_next = 1'b1;
        end else if (out_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            match_reg    <= '0;
            issuing_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            count_reg    <= count_next;
            match_reg    <= match_next;
            issuing_reg  <= issuing_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        if (cmd.start) begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
        if (take) begin
            prefix_reg     <= cmd.miss ? match_reg : rd_idx_reg;
            symbol_reg     <= cmd.miss ? byte_reg : '0;
            has_symbol_reg <= cmd.miss;
        end
    end

    // single port dictionary: entry holds {parent, symbol}
    always_ff @(posedge aclk) begin
        if (cmd.miss) begin
            mem[wr_addr] <= {match_reg, byte_reg};
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr_reg];
            rd_idx_reg  <= addr_reg;
        end
    end

    assign out_valid      = m_valid_reg;
    assign out_prefix     = prefix_reg;
    assign out_symbol     = symbol_reg;
    assign out_has_symbol = has_symbol_reg;

endmodule

// ===== hw/rtl/lz78be_ctrl.sv =====
// controller of the lz78 byte encoder: takes requests and steers the dictionary scan
// depends on lz78be_pkg
`timescale 1ns / 1ps

module lz78be_ctrl
    import lz78be_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  lz78be_stat_t  stat,
    output lz78be_cmd_t   cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (stat.hit) begin
                    if (!stat.last) begin
                        cmd.hit_step = 1'b1;
                        state_next   = ST_IDLE;
                    end else if (stat.out_free) begin
                        cmd.hit_flush = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else if (stat.exhausted) begin
                    if (stat.out_free) begin
                        cmd.miss   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.scan_en = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/lz78_byte_encoder.sv =====
// lz78 byte encoder, top level: joins the controller and the datapath
// depends on lz78be_pkg, lz78be_ctrl, lz78be_dp
//
// usage
//   input stream: one byte per request on s_tdata, s_tlast marks the last
//   byte of a stream. output stream: one result per new phrase on m_tdata
//   (prefix index, then symbol), m_tuser = has_symbol; a stream that ends
//   inside a match closes with the index alone and m_tuser low.
// timing
//   each byte is compared against the dictionary one entry a cycle, through
//   the single read port of the dictionary memory, which holds at most
//   DICT_SIZE - 1 entries. a result is registered once the scan ends and
//   the result register is free; s_tready is high only between bytes.
// reset and stall
//   reset empties the dictionary (entry count to zero, no memory sweep) and
//   puts the match at the root. the end of a stream does the same. a stalled
//   receiver holds the result register; the next byte is still taken, and
//   its own result waits until the register frees.
`timescale 1ns / 1ps

module lz78_byte_encoder
    import lz78be_pkg::*;
#(
    parameter int DICT_SIZE = DICT_SIZE_DEF,
    localparam int IDX_W    = $clog2(DICT_SIZE),
    localparam int OUT_W    = IDX_W + BYTE_W,
    localparam int TDATA_W  = ((OUT_W + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [BYTE_W-1:0]  s_tdata,    // data_byte
    input  logic               s_tlast,    // end_of_stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,    // prefix_index, symbol, zero fill
    output logic               m_tuser     // has_symbol
);

    lz78be_cmd_t       cmd;
    lz78be_stat_t      stat;
    logic [IDX_W-1:0]  out_prefix;
    logic [BYTE_W-1:0] out_symbol;

    lz78be_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lz78be_dp #(
        .DICT_SIZE (DICT_SIZE)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .in_byte        (s_tdata),
        .in_last        (s_tlast),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_prefix     (out_prefix),
        .out_symbol     (out_symbol),
        .out_has_symbol (m_tuser)
    );

    assign m_tdata = TDATA_W'({out_symbol, out_prefix});

endmodule

// ===== hw/rtl/lz78be_checker.sv =====
// port-level checks for the lz78 byte encoder, bound to the top level
// depends on assert_macros.svh and lz78_byte_encoder
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lz78be_checker #(
    parameter int TDATA_W = 16
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tuser
);

    // a stalled result stays offered
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")

    // reset leaves no result pending
    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // one byte at a time: the scan follows every accepted request
    `ASSERT_CLK(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "request taken during a scan")

    // a new result only comes out of a scan, never straight from the idle state
    `ASSERT_CLK(a_result_from_scan, aclk, aresetn, $rose(m_tvalid) |-> !$past(s_tready), "result without a scan")

    // an offered result carries known fields
    `ASSERT_CLK(a_out_known, aclk, aresetn, m_tvalid |-> !$isunknown({m_tdata, m_tuser}), "unknown result")

endmodule

bind lz78_byte_encoder lz78be_checker #(
    .TDATA_W (TDATA_W)
) u_lz78be_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
